/* sv/sfir_pkg.sv */
// ============================================================================
// sfir_pkg - shared definitions for the stereo FIR filter
// Sizes, item formats, command format between front and back, and the
// pointer and rounding helpers used by the MAC engine.
// ============================================================================
`default_nettype none

package sfir_pkg;

   localparam int TAPS         = 32;
   localparam int IDX_W        = (TAPS > 1) ? $clog2(TAPS) : 1;
   localparam int SAMPLE_W     = 24;
   localparam int COEF_W       = 16;
   localparam int COEF_INDEX_W = 5;
   localparam int PROD_W       = SAMPLE_W + COEF_W;
   localparam int ACC_W        = PROD_W + IDX_W + 1;
   localparam int FRAC_BITS    = 15;
   localparam int RND_W        = ACC_W - FRAC_BITS;

   localparam int OUT_MAX = 8388607;
   localparam int OUT_MIN = -8388608;

   localparam int CMDQ_DEPTH = 4;
   localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);
   localparam int OUTQ_DEPTH = 2;
   localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
   localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_COEF   = 1'b1;

   localparam logic [IDX_W-1:0] TAP_LAST = IDX_W'(TAPS - 1);

   typedef struct packed {
      logic                       kind;
      logic signed [SAMPLE_W-1:0] left_sample;
      logic signed [SAMPLE_W-1:0] right_sample;
      logic [COEF_INDEX_W-1:0]    coef_index;
      logic signed [COEF_W-1:0]   coef_value;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left_out;
      logic signed [SAMPLE_W-1:0] right_out;
   } rsp_type;

   // Classified item as handed from the front to the back.
   typedef struct packed {
      logic                       is_coef;
      logic                       coef_ok;
      logic [IDX_W-1:0]           coef_addr;
      logic signed [COEF_W-1:0]   coef_value;
      logic signed [SAMPLE_W-1:0] left_sample;
      logic signed [SAMPLE_W-1:0] right_sample;
   } cmd_type;

   function automatic logic [IDX_W-1:0] ptr_next(input logic [IDX_W-1:0] p);
      if (p == TAP_LAST) begin
         return '0;
      end
      return p + IDX_W'(1);
   endfunction

   function automatic logic [IDX_W-1:0] ptr_prev(input logic [IDX_W-1:0] p);
      if (p == '0) begin
         return TAP_LAST;
      end
      return p - IDX_W'(1);
   endfunction

   // Round half towards plus infinity, then clamp to the 24-bit range.
   function automatic logic signed [SAMPLE_W-1:0] round_sat(
      input logic signed [ACC_W-1:0] acc);
      logic signed [ACC_W-1:0] bias;
      logic signed [ACC_W-1:0] biased;
      logic signed [RND_W-1:0] r;
      logic signed [RND_W-1:0] r_max;
      logic signed [RND_W-1:0] r_min;
      bias   = ACC_W'(2 ** (FRAC_BITS - 1));
      biased = acc + bias;
      r      = biased[ACC_W-1:FRAC_BITS];
      r_max  = RND_W'(OUT_MAX);
      r_min  = RND_W'(OUT_MIN);
      if (r > r_max) begin
         return SAMPLE_W'(OUT_MAX);
      end
      if (r < r_min) begin
         return SAMPLE_W'(OUT_MIN);
      end
      return r[SAMPLE_W-1:0];
   endfunction

endpackage

`default_nettype wire

/* sv/sfir_front.sv */
// ============================================================================
// sfir_front - input queue and item classification
// Takes items from the push/full port, decodes them into commands and
// holds them in a short queue until the MAC engine takes them.
// ============================================================================
`default_nettype none

module sfir_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   output logic                   full,
   input  wire sfir_pkg::req_type req_data,
   output logic                   cmd_valid,
   output sfir_pkg::cmd_type      cmd_data,
   input  wire logic              cmd_take
);

   sfir_pkg::cmd_type                    q_ff [sfir_pkg::CMDQ_DEPTH];
   logic [sfir_pkg::CMDQ_PTR_W-1:0]      wr_ff, wr_in;
   logic [sfir_pkg::CMDQ_PTR_W-1:0]      rd_ff, rd_in;
   logic [sfir_pkg::CMDQ_CNT_W-1:0]      cnt_ff, cnt_in;
   sfir_pkg::cmd_type                    cmd_new;
   logic                                 do_push;
   logic                                 do_pop;

   // Decode the item once, on the way in.
   always_comb begin
      cmd_new.is_coef      = (req_data.kind == sfir_pkg::KIND_COEF);
      cmd_new.coef_ok      = (32'(req_data.coef_index) < sfir_pkg::TAPS);
      cmd_new.coef_addr    = sfir_pkg::IDX_W'(req_data.coef_index);
      cmd_new.coef_value   = req_data.coef_value;
      cmd_new.left_sample  = req_data.left_sample;
      cmd_new.right_sample = req_data.right_sample;
   end

   assign full      = (cnt_ff == sfir_pkg::CMDQ_CNT_W'(sfir_pkg::CMDQ_DEPTH));
   assign cmd_valid = (cnt_ff != '0);
   assign cmd_data  = q_ff[rd_ff];
   assign do_push   = push && !full;
   assign do_pop    = cmd_take && cmd_valid;

   always_comb begin
      wr_in  = do_push ? wr_ff + sfir_pkg::CMDQ_PTR_W'(1) : wr_ff;
      rd_in  = do_pop ? rd_ff + sfir_pkg::CMDQ_PTR_W'(1) : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + sfir_pkg::CMDQ_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - sfir_pkg::CMDQ_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ff] <= cmd_new;
      end
   end

endmodule

`default_nettype wire

/* sv/sfir_back.sv */
// ============================================================================
// sfir_back - MAC engine and result queue
// Holds the delay lines and coefficient store, runs one shared multiplier
// over every tap of both channels and queues the rounded results.
// ============================================================================
`default_nettype none

module sfir_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              cmd_valid,
   input  wire sfir_pkg::cmd_type cmd_data,
   output logic                   cmd_take,
   output logic                   empty,
   input  wire logic              pop,
   output sfir_pkg::rsp_type      rsp_data
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_RUN    = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   // Delay lines are circular buffers; head points at the newest sample.
   logic signed [sfir_pkg::SAMPLE_W-1:0] left_mem  [sfir_pkg::TAPS];
   logic signed [sfir_pkg::SAMPLE_W-1:0] right_mem [sfir_pkg::TAPS];
   logic signed [sfir_pkg::COEF_W-1:0]   coef_mem  [sfir_pkg::TAPS];
   logic [sfir_pkg::TAPS-1:0]            line_ok_ff;

   logic [sfir_pkg::IDX_W-1:0] head_ff, head_in;
   logic [sfir_pkg::IDX_W-1:0] tap_ff, tap_in;
   logic [sfir_pkg::IDX_W-1:0] ptr_ff, ptr_in;
   logic                       chan_ff, chan_in;
   logic [sfir_pkg::IDX_W-1:0] head_new;

   // Read stage
   logic                                 rd_valid_ff, rd_chan_ff, rd_last_ff;
   logic signed [sfir_pkg::COEF_W-1:0]   coef_rd_ff;
   logic signed [sfir_pkg::SAMPLE_W-1:0] samp_rd_ff;
   logic                                 samp_ok_ff;
   logic signed [sfir_pkg::SAMPLE_W-1:0] samp_sel;

   // Multiply stage
   logic                                 prod_valid_ff, prod_chan_ff, prod_last_ff;
   logic signed [sfir_pkg::PROD_W-1:0]   prod_ff;

   logic signed [sfir_pkg::ACC_W-1:0]    acc_l_ff, acc_r_ff;

   // Result queue
   sfir_pkg::rsp_type                    outq_ff [sfir_pkg::OUTQ_DEPTH];
   logic [sfir_pkg::OUTQ_PTR_W-1:0]      outq_wr_ff, outq_rd_ff;
   logic [sfir_pkg::OUTQ_CNT_W-1:0]      outq_cnt_ff, outq_cnt_in;

   logic start_sample, start_coef, issue, issue_last, finish_push, do_pop;

   assign head_new     = sfir_pkg::ptr_next(head_ff);
   assign start_sample = (state_ff == ST_IDLE) && cmd_valid && !cmd_data.is_coef &&
                         (outq_cnt_ff < sfir_pkg::OUTQ_CNT_W'(sfir_pkg::OUTQ_DEPTH));
   assign start_coef   = (state_ff == ST_IDLE) && cmd_valid && cmd_data.is_coef;
   assign cmd_take     = start_sample || start_coef;
   assign issue        = (state_ff == ST_RUN);
   assign issue_last   = issue && chan_ff && (tap_ff == sfir_pkg::TAP_LAST);
   assign finish_push  = (state_ff == ST_FINISH);
   assign empty        = (outq_cnt_ff == '0);
   assign do_pop       = pop && !empty;
   assign rsp_data     = outq_ff[outq_rd_ff];
   assign samp_sel     = samp_ok_ff ? samp_rd_ff : '0;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start_sample) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (issue_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (prod_valid_ff && prod_last_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      head_in = start_sample ? head_new : head_ff;
      tap_in  = tap_ff;
      ptr_in  = ptr_ff;
      chan_in = chan_ff;
      if (start_sample) begin
         tap_in  = '0;
         ptr_in  = head_new;
         chan_in = 1'b0;
      end else if (issue) begin
         chan_in = !chan_ff;
         if (chan_ff) begin
            tap_in = tap_ff + sfir_pkg::IDX_W'(1);
            ptr_in = sfir_pkg::ptr_prev(ptr_ff);
         end
      end
   end

   always_comb begin
      outq_cnt_in = outq_cnt_ff;
      if (finish_push && !do_pop) begin
         outq_cnt_in = outq_cnt_ff + sfir_pkg::OUTQ_CNT_W'(1);
      end else if (do_pop && !finish_push) begin
         outq_cnt_in = outq_cnt_ff - sfir_pkg::OUTQ_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         head_ff       <= '0;
         tap_ff        <= '0;
         ptr_ff        <= '0;
         chan_ff       <= 1'b0;
         line_ok_ff    <= '0;
         rd_valid_ff   <= 1'b0;
         prod_valid_ff <= 1'b0;
         outq_wr_ff    <= '0;
         outq_rd_ff    <= '0;
         outq_cnt_ff   <= '0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         tap_ff        <= tap_in;
         ptr_ff        <= ptr_in;
         chan_ff       <= chan_in;
         if (start_sample) begin
            line_ok_ff[head_new] <= 1'b1;
         end
         rd_valid_ff   <= issue;
         prod_valid_ff <= rd_valid_ff;
         if (finish_push) begin
            outq_wr_ff <= outq_wr_ff + sfir_pkg::OUTQ_PTR_W'(1);
         end
         if (do_pop) begin
            outq_rd_ff <= outq_rd_ff + sfir_pkg::OUTQ_PTR_W'(1);
         end
         outq_cnt_ff   <= outq_cnt_in;
      end
   end

   // Stores: writes only happen while the sequencer is idle.
   always_ff @(posedge clock) begin
      if (start_sample) begin
         left_mem[head_new]  <= cmd_data.left_sample;
         right_mem[head_new] <= cmd_data.right_sample;
      end
      if (start_coef && cmd_data.coef_ok) begin
         coef_mem[cmd_data.coef_addr] <= cmd_data.coef_value;
      end
      coef_rd_ff <= coef_mem[tap_ff];
      samp_rd_ff <= chan_ff ? right_mem[ptr_ff] : left_mem[ptr_ff];
   end

   always_ff @(posedge clock) begin
      samp_ok_ff   <= line_ok_ff[ptr_ff];
      rd_chan_ff   <= chan_ff;
      rd_last_ff   <= issue_last;
      prod_ff      <= coef_rd_ff * samp_sel;
      prod_chan_ff <= rd_chan_ff;
      prod_last_ff <= rd_last_ff;
      if (start_sample) begin
         acc_l_ff <= '0;
         acc_r_ff <= '0;
      end else if (prod_valid_ff) begin
         if (prod_chan_ff) begin
            acc_r_ff <= acc_r_ff + sfir_pkg::ACC_W'(prod_ff);
         end else begin
            acc_l_ff <= acc_l_ff + sfir_pkg::ACC_W'(prod_ff);
         end
      end
      if (finish_push) begin
         outq_ff[outq_wr_ff].left_out  <= sfir_pkg::round_sat(acc_l_ff);
         outq_ff[outq_wr_ff].right_out <= sfir_pkg::round_sat(acc_r_ff);
      end
   end

   a_outq_bound: assert property (@(posedge clock) disable iff (reset)
      outq_cnt_ff <= sfir_pkg::OUTQ_CNT_W'(sfir_pkg::OUTQ_DEPTH))
      else $error("result queue count beyond its depth");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      finish_push |-> (outq_cnt_ff < sfir_pkg::OUTQ_CNT_W'(sfir_pkg::OUTQ_DEPTH)))
      else $error("result written into a full queue");

   a_start_runs: assert property (@(posedge clock) disable iff (reset)
      start_sample |=> (state_ff == ST_RUN) && (tap_ff == '0) && !chan_ff)
      else $error("sample item did not start the tap sweep");

   a_prod_in_sweep: assert property (@(posedge clock) disable iff (reset)
      prod_valid_ff |-> (state_ff == ST_RUN || state_ff == ST_DRAIN))
      else $error("product outside a tap sweep");

   a_finish_after_last: assert property (@(posedge clock) disable iff (reset)
      finish_push |-> $past(prod_valid_ff && prod_last_ff))
      else $error("result finished before the last product");

endmodule

`default_nettype wire

/* sv/stereo_fir_filter.sv */
// ============================================================================
// stereo_fir_filter - stereo direct-form FIR filter, top level
// Input queue and classifier in front of a shared-MAC engine that filters
// the left and right channels through one coefficient store.
// ============================================================================
//
// Usage. Items enter through push/full: an item is taken at a rising edge
// with push high and full low. A sample item (kind 0) shifts one left and
// one right sample into the delay lines and later yields one result; a
// coefficient item (kind 1) writes one tap and yields no result. Results
// leave through empty/pop: the oldest result sits on rsp_data while empty is
// low and is taken at an edge with pop high.
// Timing. A coefficient item is written while the engine is idle and starts
// no sweep. A sample item occupies the engine through the RUN, DRAIN and
// FINISH states, set by the single shared multiplier, which visits every
// tap once per channel; the result is written to the result queue in FINISH.
// A four-entry input queue absorbs bursts of items meanwhile.
// Reset clears both delay lines to zero and empties both queues; the
// coefficient store keeps no reset value and every tap must be written
// before the first sample item. If the receiver stalls, up to two results
// wait in the result queue, after which the engine holds the next sample
// item and the input queue fills until full rises.
//
`default_nettype none

module stereo_fir_filter (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   output logic                   full,
   input  wire sfir_pkg::req_type req_data,
   output logic                   empty,
   input  wire logic              pop,
   output sfir_pkg::rsp_type      rsp_data
);

   // Classified items waiting for the engine.
   logic              cmd_valid;
   logic              cmd_take;
   sfir_pkg::cmd_type cmd_data;

   // The front decodes items and queues them, so the producer is never held
   // up by a sweep in progress until the queue itself runs full.
   sfir_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_take  (cmd_take)
   );

   // The back owns all filter state and the result queue; it takes a new
   // command only when idle, and a sample command only when a result slot
   // is free.
   sfir_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_take  (cmd_take),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
